// File: rtl/one_shot_and_periodic_timer_table_top_assert.svh
// Assertion macros for the timer table top level.
// Expects i_clk and i_rst_n in the scope where the macros are used.
`ifndef ONE_SHOT_AND_PERIODIC_TIMER_TABLE_TOP_ASSERT_SVH
`define ONE_SHOT_AND_PERIODIC_TIMER_TABLE_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TMR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TMR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/tmr_pkg.sv
// Shared types and constants for the timer table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tmr_pkg;

    localparam int EVENT_SLOTS = 32;
    localparam int IDX_W       = $clog2(EVENT_SLOTS);
    localparam int ID_W        = 6;
    localparam int TICKS_W     = 16;
    localparam int ELAPSED_W   = 10;

    typedef enum logic [1:0] {
        ACT_ARM    = 2'd0,
        ACT_DISARM = 2'd1,
        ACT_QUERY  = 2'd2,
        ACT_TICK   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        KIND_ACK   = 2'd0,
        KIND_QUERY = 2'd1,
        KIND_FIRED = 2'd2,
        KIND_DONE  = 2'd3
    } t_kind;

    typedef struct packed {
        t_action                     action;
        logic                        id_ok;
        logic [ID_W-1:0]             id;
        logic signed [TICKS_W-1:0]   ticks;
        logic [ELAPSED_W-1:0]        elapsed;
    } t_cmd;

    typedef struct packed {
        t_kind           kind;
        logic [ID_W-1:0] id;
        logic            slot_enabled;
        logic            last;
    } t_res;

endpackage
`default_nettype wire

// File: rtl/one_shot_and_periodic_timer_table_top.sv
// Timer table with one-shot timers and daemons, top level.
// Uses tmr_pkg, tmr_front, tmr_back and the assertion macro header.
//
// Input channel (i_valid/o_ready) carries an action, a slot id, an arm count
// and an elapsed cost. Output channel (o_valid/i_ready) carries result items:
// kind, slot id, enable bit of a queried slot, and a last flag.
// Arm, disarm and query give one result each through the queue and the
// result register; a new command can start every cycle while the output is
// free and no tick runs. A tick walks every slot, one slot per cycle unless
// stalled, through the registered read port of the count memory: it gives
// one result per slot that fires, in ascending slot order, then a done item.
// The back end stays busy through the walk and the done state, plus stalls.
// A two-entry queue sits between the front and back end, so inputs are taken
// while a tick walk runs or the receiver stalls, until the queue is full.
// A stalled receiver holds the walk on the slot that fires; nothing is lost.
// Reset disables every slot and empties the queue and the result register;
// counts need no clearing since a count is only read on an enabled slot.
`timescale 1ns / 1ps
`default_nettype none
`include "one_shot_and_periodic_timer_table_top_assert.svh"
module one_shot_and_periodic_timer_table_top (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic [1:0]                           i_action,
    input  wire logic [tmr_pkg::ID_W-1:0]             i_event_id,
    input  wire logic signed [tmr_pkg::TICKS_W-1:0]   i_timer_ticks,
    input  wire logic [tmr_pkg::ELAPSED_W-1:0]        i_elapsed,
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output logic [1:0]                                o_kind,
    output logic [tmr_pkg::ID_W-1:0]                  o_fired_id,
    output logic                                      o_slot_enabled,
    output logic                                      o_last
);

    logic          w_cmd_valid;
    tmr_pkg::t_cmd w_cmd;
    logic          w_cmd_pop;
    tmr_pkg::t_res w_res;

    tmr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_action      (i_action),
        .i_event_id    (i_event_id),
        .i_timer_ticks (i_timer_ticks),
        .i_elapsed     (i_elapsed),
        .o_cmd_valid   (w_cmd_valid),
        .o_cmd         (w_cmd),
        .i_cmd_pop     (w_cmd_pop)
    );

    tmr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_res_valid (o_valid),
        .o_res       (w_res),
        .i_res_ready (i_ready)
    );

    assign o_kind         = w_res.kind;
    assign o_fired_id     = w_res.id;
    assign o_slot_enabled = w_res.slot_enabled;
    assign o_last         = w_res.last;

    `TMR_ASSERT_IMP(a_not_last_is_fired, o_valid && !o_last, (o_kind == tmr_pkg::KIND_FIRED) && (o_fired_id != '0) && !o_slot_enabled, "non-final result is not a fired slot")
    `TMR_ASSERT_IMP(a_done_shape, o_valid && (o_kind == tmr_pkg::KIND_DONE), o_last && (o_fired_id == '0) && !o_slot_enabled, "malformed tick done result")
    `TMR_ASSERT_NEXT(a_fire_order, o_valid && i_ready && (o_kind == tmr_pkg::KIND_FIRED), !(o_valid && (o_kind == tmr_pkg::KIND_FIRED) && (o_fired_id <= $past(o_fired_id))), "fired slots out of order")

endmodule
`default_nettype wire

// File: rtl/tmr_front.sv
// Front end of the timer table: accepts items, checks the slot id and
// queues commands for the back end. Depends on tmr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tmr_front (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic [1:0]                           i_action,
    input  wire logic [tmr_pkg::ID_W-1:0]             i_event_id,
    input  wire logic signed [tmr_pkg::TICKS_W-1:0]   i_timer_ticks,
    input  wire logic [tmr_pkg::ELAPSED_W-1:0]        i_elapsed,
    output logic                                      o_cmd_valid,
    output tmr_pkg::t_cmd                             o_cmd,
    input  wire logic                                 i_cmd_pop
);

    localparam logic [1:0] QUEUE_FULL = 2'd2;

    tmr_pkg::t_cmd r_q [2];
    logic          r_wr_ptr, n_wr_ptr;
    logic          r_rd_ptr, n_rd_ptr;
    logic [1:0]    r_count, n_count;
    logic          w_push;
    tmr_pkg::t_cmd w_cmd;

    assign o_ready     = (r_count != QUEUE_FULL);
    assign w_push      = i_valid && o_ready;
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_rd_ptr];

    // Classify: slot zero and ids past the table are not real slots.
    always_comb begin
        w_cmd.action  = tmr_pkg::t_action'(i_action);
        w_cmd.id      = i_event_id;
        w_cmd.id_ok   = (i_event_id != '0) &&
                        ({1'b0, i_event_id} < (tmr_pkg::ID_W+1)'(tmr_pkg::EVENT_SLOTS));
        w_cmd.ticks   = i_timer_ticks;
        w_cmd.elapsed = i_elapsed;
    end

    always_comb begin
        n_wr_ptr = w_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_cmd_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, w_push} - {1'b0, i_cmd_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

endmodule
`default_nettype wire

// File: rtl/tmr_back.sv
// Back end of the timer table: slot enables, count memory, tick walk and
// the result register. Depends on tmr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tmr_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cmd_valid,
    input  wire tmr_pkg::t_cmd i_cmd,
    output logic               o_cmd_pop,
    output logic               o_res_valid,
    output tmr_pkg::t_res      o_res,
    input  wire logic          i_res_ready
);

    localparam int N = tmr_pkg::EVENT_SLOTS;
    localparam int W = tmr_pkg::IDX_W;
    localparam int C = tmr_pkg::TICKS_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_DONE
    } t_state;

    t_state                           r_state, n_state;
    logic [W-1:0]                     r_idx, n_idx;
    logic [tmr_pkg::ELAPSED_W-1:0]    r_elapsed;
    logic                             r_res_valid;
    tmr_pkg::t_res                    r_res;

    logic                             r_en [N];
    logic signed [C-1:0]              r_cnt [N];
    logic signed [C-1:0]              r_rd_data;

    logic                             w_out_free;
    logic                             w_load;
    tmr_pkg::t_res                    w_res;
    logic                             w_tick_start;
    logic                             w_mem_we;
    logic [W-1:0]                     w_mem_addr;
    logic signed [C-1:0]              w_mem_data;
    logic                             w_en_we;
    logic [W-1:0]                     w_en_addr;
    logic                             w_en_val;
    logic [W-1:0]                     w_cmd_idx;
    logic signed [C:0]                w_diff;
    logic                             w_daemon;
    logic                             w_timer;
    logic                             w_expire;
    logic                             w_fire;

    assign w_out_free  = !r_res_valid || i_res_ready;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;
    assign w_cmd_idx   = i_cmd.id[W-1:0];

    always_comb begin
        w_diff   = {r_rd_data[C-1], r_rd_data} - (C+1)'(r_elapsed);
        w_daemon = (r_rd_data == -(C)'(1));
        w_timer  = !r_rd_data[C-1] && (r_rd_data != '0);
        w_expire = w_timer && (w_diff <= (C+1)'(1));
        w_fire   = r_en[r_idx] && (w_daemon || w_expire);
    end

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        o_cmd_pop    = 1'b0;
        w_load       = 1'b0;
        w_res        = '0;
        w_tick_start = 1'b0;
        w_mem_we     = 1'b0;
        w_mem_addr   = r_idx;
        w_mem_data   = w_diff[C-1:0];
        w_en_we      = 1'b0;
        w_en_addr    = r_idx;
        w_en_val     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                // Read address of the walk starts at slot zero.
                n_idx = '0;
                if (i_cmd_valid && w_out_free) begin
                    o_cmd_pop = 1'b1;
                    w_res.id  = i_cmd.id;
                    w_res.last = 1'b1;
                    case (i_cmd.action)
                        tmr_pkg::ACT_ARM: begin
                            w_load     = 1'b1;
                            w_res.kind = tmr_pkg::KIND_ACK;
                            w_mem_we   = i_cmd.id_ok;
                            w_mem_addr = w_cmd_idx;
                            w_mem_data = i_cmd.ticks;
                            w_en_we    = i_cmd.id_ok;
                            w_en_addr  = w_cmd_idx;
                            w_en_val   = 1'b1;
                        end
                        tmr_pkg::ACT_DISARM: begin
                            w_load     = 1'b1;
                            w_res.kind = tmr_pkg::KIND_ACK;
                            w_en_we    = i_cmd.id_ok;
                            w_en_addr  = w_cmd_idx;
                            w_en_val   = 1'b0;
                        end
                        tmr_pkg::ACT_QUERY: begin
                            w_load             = 1'b1;
                            w_res.kind         = tmr_pkg::KIND_QUERY;
                            w_res.slot_enabled = i_cmd.id_ok && r_en[w_cmd_idx];
                        end
                        tmr_pkg::ACT_TICK: begin
                            w_tick_start = 1'b1;
                            n_state      = ST_TICK;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_TICK: begin
                // Hold the slot while a firing result cannot be placed.
                if (!w_fire || w_out_free) begin
                    if (r_en[r_idx] && w_timer) begin
                        w_mem_we   = 1'b1;
                        w_mem_data = w_expire ? '0 : w_diff[C-1:0];
                        w_en_we    = w_expire;
                        w_en_val   = 1'b0;
                    end
                    if (w_fire) begin
                        w_load     = 1'b1;
                        w_res.kind = tmr_pkg::KIND_FIRED;
                        w_res.id   = tmr_pkg::ID_W'(r_idx);
                    end
                    if (r_idx == W'(N-1)) begin
                        n_state = ST_DONE;
                    end else begin
                        n_idx = r_idx + W'(1);
                    end
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    w_load     = 1'b1;
                    w_res.kind = tmr_pkg::KIND_DONE;
                    w_res.last = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (w_load) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
        if (w_load) begin
            r_res <= w_res;
        end
        if (w_tick_start) begin
            r_elapsed <= i_cmd.elapsed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N; i++) begin
                r_en[i] <= 1'b0;
            end
        end else if (w_en_we) begin
            r_en[w_en_addr] <= w_en_val;
        end
    end

    // Count memory: one write port, registered read at the next walk index.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_cnt[w_mem_addr] <= w_mem_data;
        end
        r_rd_data <= r_cnt[n_idx];
    end

endmodule
`default_nettype wire
